FILE: rtl/bmx_pkg.sv
// ----------------------------------------------------------------------------
// bmx_pkg
// Shared constants and types for the bounded maximum-xor search block.
// ----------------------------------------------------------------------------
package bmx_pkg;

  localparam int CAPACITY   = 1024;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // running answer handed from cell to cell
  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] best;
  } bmx_acc_t;

endpackage

FILE: rtl/bmx_cell.sv
// ----------------------------------------------------------------------------
// bmx_cell
// One store entry with its compare stage: folds its value into the running
// answer from the previous cell and registers the result for the next one.
// ----------------------------------------------------------------------------
module bmx_cell (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [bmx_pkg::VALUE_BITS-1:0] wr_data,
  input  logic                           entry_ok,
  input  logic [bmx_pkg::VALUE_BITS-1:0] qx,
  input  logic [31:0]                    qlim,
  input  bmx_pkg::bmx_acc_t              acc_in,
  output bmx_pkg::bmx_acc_t              acc_out
);
  import bmx_pkg::*;

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] xo;
  logic                  hit;
  bmx_acc_t              acc_nxt;
  bmx_acc_t              acc_r;

  always_comb begin
    xo      = val_r ^ qx;
    // limit is compared at its full width
    hit     = entry_ok && ({32'd0, 32'(val_r)} <= {32'd0, qlim});
    acc_nxt = acc_in;
    if (hit && (!acc_in.found || xo > acc_in.best)) begin
      acc_nxt.best = xo;
    end
    if (hit) begin
      acc_nxt.found = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_r <= wr_data;
    end
    acc_r <= acc_nxt;
  end

  assign acc_out = acc_r;

endmodule

FILE: rtl/bounded_max_xor_search.sv
// ----------------------------------------------------------------------------
// bounded_max_xor_search
// Store of up to CAPACITY values answering bounded maximum-xor queries.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low: in_cmd
//   selects insert, query or clear, in_operand_value is the value or the
//   query x, in_limit bounds the eligible stored values for a query.
//   Every command gives exactly one result beat on out_* marked by out_valid
//   for one cycle; the receiver cannot stall it.
//   Insert, clear and unused codes answer in the cycle after acceptance and
//   leave busy low, so one such command can be taken every cycle.
//   A query runs its answer through the row of CAPACITY entry cells, one
//   cell per cycle; busy is high until the result shows, so no new command
//   is taken while a query runs. The row length sets how long a query takes.
//   An insert into a full store answers with out_dropped high.
//   Reset (rst_n low, synchronous) empties the store and drops any query
//   in flight; stored values are not cleared, the entry count guards them.
// ----------------------------------------------------------------------------
module bounded_max_xor_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_operand_value,
  input  logic [31:0] in_limit,
  output logic        out_valid,
  output logic        out_found,
  output logic [31:0] out_best_xor,
  output logic        out_dropped
);
  import bmx_pkg::*;

  logic                  accept;
  logic                  busy_r;
  logic [IDX_W-1:0]      step_r;
  logic [CNT_W-1:0]      count_r;
  logic [VALUE_BITS-1:0] x_r;
  logic [31:0]           lim_r;
  logic                  out_valid_r;
  logic                  out_query_r;
  logic                  dropped_r;
  logic                  ins_ok;
  logic [VALUE_BITS-1:0] in_val;

  bmx_acc_t acc [CAPACITY+1];

  assign accept = start && !busy_r;
  assign in_val = VALUE_BITS'(in_operand_value);
  assign ins_ok = accept && (in_cmd == CMD_INSERT) && (count_r < CNT_W'(CAPACITY));

  assign acc[0] = '{found: 1'b0, best: '0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bmx_cell u_cell (
      .clk      (clk),
      .wr_en    (ins_ok && (count_r == CNT_W'(i))),
      .wr_data  (in_val),
      .entry_ok (CNT_W'(i) < count_r),
      .qx       (x_r),
      .qlim     (lim_r),
      .acc_in   (acc[i]),
      .acc_out  (acc[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      out_query_r <= 1'b0;
      dropped_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (busy_r) begin
        step_r <= step_r + IDX_W'(1);
        if (step_r == IDX_W'(CAPACITY - 1)) begin
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end
      end else if (accept) begin
        dropped_r   <= 1'b0;
        out_query_r <= 1'b0;
        unique case (in_cmd)
          CMD_INSERT: begin
            out_valid_r <= 1'b1;
            if (ins_ok) begin
              count_r <= count_r + CNT_W'(1);
            end else begin
              dropped_r <= 1'b1;
            end
          end
          CMD_QUERY: begin
            busy_r      <= 1'b1;
            step_r      <= '0;
            out_query_r <= 1'b1;
          end
          CMD_CLEAR: begin
            out_valid_r <= 1'b1;
            count_r     <= '0;
          end
          default: begin
            out_valid_r <= 1'b1;
          end
        endcase
      end
    end
  end

  // query operands stay put while the answer walks the row
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r   <= in_val;
      lim_r <= in_limit;
    end
  end

  assign busy         = busy_r;
  assign out_valid    = out_valid_r;
  assign out_found    = out_query_r && acc[CAPACITY].found;
  assign out_best_xor = out_query_r ? 32'(acc[CAPACITY].best) : 32'd0;
  assign out_dropped  = dropped_r;

endmodule

FILE: rtl/bmx_checker.sv
// ----------------------------------------------------------------------------
// bmx_checker
// Port-level checks for the bounded maximum-xor search block.
// ----------------------------------------------------------------------------
module bmx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_found,
  input logic [31:0] out_best_xor,
  input logic        out_dropped
);
  import bmx_pkg::*;

  // a query holds the block busy and shows no result right away
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == CMD_QUERY |=> busy && !out_valid)
    else $error("query beat did not start a search");

  // other commands answer in the next cycle
  a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd != CMD_QUERY |=> out_valid && !busy)
    else $error("non-query beat did not answer next cycle");

  a_nofind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_best_xor == 32'd0)
    else $error("best_xor not zero without a find");

  a_drop_nofind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> !out_found)
    else $error("dropped and found in one beat");

endmodule

bind bounded_max_xor_search bmx_checker u_bmx_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_cmd       (in_cmd),
  .out_valid    (out_valid),
  .out_found    (out_found),
  .out_best_xor (out_best_xor),
  .out_dropped  (out_dropped)
);

FILE: sim/tb_bounded_max_xor_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_max_xor_search
// Self-checking bench for the bounded maximum-xor search store.
// A command queue feeds a clocked driver. Each accepted command updates a
// behavioral copy of the store, and that copy gives the expected answer. A
// clocked monitor checks every result beat against the oldest expected answer.
// Stimulus is a short directed pass, then random insert/query/clear episodes
// and one run that fills the store past capacity, under three sender idle
// rates.
// ----------------------------------------------------------------------------
module tb_bounded_max_xor_search;
  import bmx_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [31:0] VAL_MASK    = (VALUE_BITS >= 32) ? 32'hFFFF_FFFF :
                                        ((32'd1 << VALUE_BITS) - 32'd1);
  localparam int          STALL_LIMIT = 8 * CAPACITY + 1000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] operand;
    logic [31:0] limit;
  } bmx_cmd_t;

  typedef struct packed {
    logic        found;
    logic [31:0] best_xor;
    logic        dropped;
  } bmx_answer_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        start            = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd           = CMD_UNUSED;
  logic [31:0] in_operand_value = '0;
  logic [31:0] in_limit         = '0;
  logic        out_valid;
  logic        out_found;
  logic [31:0] out_best_xor;
  logic        out_dropped;

  bounded_max_xor_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_operand_value (in_operand_value),
    .in_limit         (in_limit),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_best_xor     (out_best_xor),
    .out_dropped      (out_dropped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // command traffic and expected answers
  bmx_cmd_t    cmd_q[$];
  bmx_answer_t answer_q[$];
  bmx_cmd_t    cur_cmd = '0;
  bit          holding = 1'b0;
  int          idle_pct = 0;
  int          calm_left = 0;
  bit          hold_off;

  // behavioral copy of the store
  logic [31:0] stored_vals [CAPACITY];
  int          stored_n = 0;

  // values inserted since the last clear, as seen by the generator
  logic [31:0] gen_vals[$];

  int n_cmds = 0;
  int n_queries = 0;
  int n_found = 0;
  int n_dropped = 0;
  int n_errors = 0;
  int stall_cycles = 0;

  task automatic predict_answer(input bmx_cmd_t c);
    bmx_answer_t r;
    logic [31:0] v;
    logic [31:0] x;
    int          i;
    r = '0;
    v = c.operand & VAL_MASK;
    case (c.cmd)
      CMD_INSERT: begin
        if (stored_n < CAPACITY) begin
          stored_vals[stored_n] = v;
          stored_n++;
        end else begin
          r.dropped = 1'b1;
          n_dropped++;
        end
      end
      CMD_QUERY: begin
        n_queries++;
        for (i = 0; i < stored_n; i++) begin
          if (stored_vals[i] <= c.limit) begin
            x = stored_vals[i] ^ v;
            if (!r.found || x > r.best_xor) r.best_xor = x;
            r.found = 1'b1;
          end
        end
        if (r.found) n_found++;
      end
      CMD_CLEAR: stored_n = 0;
      default: ;
    endcase
    answer_q.insert(answer_q.size(), r);
  endtask

  // driver: one command beat offered at a time, start held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      holding = 1'b0;
    end else begin
      if (start && !busy) begin
        predict_answer(cur_cmd);
        n_cmds++;
        holding = 1'b0;
      end
      if (!holding && cmd_q.size() > 0) begin
        if (calm_left > 0) begin
          calm_left--;
          hold_off = 1'b0;
        end else begin
          if ($urandom_range(99) < 3) calm_left = $urandom_range(60, 20);
          hold_off = ($urandom_range(99) < idle_pct);
        end
        if (!hold_off) begin
          cur_cmd = cmd_q.pop_front();
          holding = 1'b1;
        end
      end
      start            <= holding;
      in_cmd           <= cur_cmd.cmd;
      in_operand_value <= cur_cmd.operand;
      in_limit         <= cur_cmd.limit;
    end
  end

  // monitor: every result beat against the oldest expected answer
  always @(posedge clk) begin
    bmx_answer_t exp_a;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        $display("%0t: result beat with nothing expected (found %b best_xor %h dropped %b)",
                 $time, out_found, out_best_xor, out_dropped);
        n_errors++;
      end else begin
        exp_a = answer_q.pop_front();
        if (out_found !== exp_a.found) begin
          $display("%0t: found mismatch, expected %b, got %b", $time, exp_a.found, out_found);
          n_errors++;
        end
        if (out_best_xor !== exp_a.best_xor) begin
          $display("%0t: best_xor mismatch, expected %h, got %h",
                   $time, exp_a.best_xor, out_best_xor);
          n_errors++;
        end
        if (out_dropped !== exp_a.dropped) begin
          $display("%0t: dropped mismatch, expected %b, got %b",
                   $time, exp_a.dropped, out_dropped);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d answers outstanding",
                 $time, stall_cycles, answer_q.size());
        $display("FAIL bounded_max_xor_search");
        $finish;
      end
    end
  end

  task automatic push_cmd(input logic [1:0] c, input logic [31:0] v, input logic [31:0] l);
    bmx_cmd_t item;
    item.cmd = c;
    item.operand = v;
    item.limit = l;
    cmd_q.insert(cmd_q.size(), item);
    if (c == CMD_INSERT && gen_vals.size() < CAPACITY)
      gen_vals.insert(gen_vals.size(), v & VAL_MASK);
    if (c == CMD_CLEAR) gen_vals.delete();
  endtask

  function automatic logic [31:0] pick_value(input logic [31:0] base);
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return base ^ ($urandom() >> $urandom_range(31, 8));
      7:          return $urandom_range(15);
      8: begin
        case ($urandom_range(3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default:    return ~base ^ $urandom_range(255);
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    logic [31:0] s;
    if (gen_vals.size() == 0 || $urandom_range(4) == 0) begin
      case ($urandom_range(3))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        default: return $urandom();
      endcase
    end
    s = gen_vals[$urandom_range(gen_vals.size() - 1)];
    case ($urandom_range(3))
      0:       return s;
      1:       return s - 32'd1;
      2:       return s + 32'd1;
      default: return s ^ ($urandom() >> $urandom_range(31, 20));
    endcase
  endfunction

  function automatic logic [31:0] pick_x(input logic [31:0] base);
    if (gen_vals.size() > 0 && $urandom_range(2) == 0)
      return ~gen_vals[$urandom_range(gen_vals.size() - 1)] ^ $urandom_range(7);
    return pick_value(base);
  endfunction

  // random episodes: mostly inserts and queries, with clears and unused codes as noise
  task automatic run_mix(input int n);
    logic [31:0] base;
    int          r;
    base = $urandom();
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 4) begin
        push_cmd(CMD_CLEAR, $urandom(), $urandom());
        base = $urandom();
      end else if (r < 7) begin
        push_cmd(CMD_UNUSED, $urandom(), $urandom());
      end else if (r < 30) begin
        push_cmd(CMD_QUERY, pick_x(base), pick_limit());
      end else begin
        push_cmd(CMD_INSERT, pick_value(base), $urandom());
      end
    end
  endtask

  // fill the store past capacity, query it full, then empty it
  task automatic run_fill();
    logic [31:0] base;
    base = $urandom();
    push_cmd(CMD_CLEAR, $urandom(), $urandom());
    repeat (CAPACITY + 4) begin
      push_cmd(CMD_INSERT, pick_value(base), $urandom());
      if ($urandom_range(127) == 0) push_cmd(CMD_QUERY, pick_x(base), pick_limit());
    end
    repeat (4) push_cmd(CMD_QUERY, pick_x(base), pick_limit());
    push_cmd(CMD_INSERT, 32'hFFFF_FFFF, $urandom());
    push_cmd(CMD_INSERT, 32'h0000_0000, $urandom());
    push_cmd(CMD_QUERY, 32'h0000_0000, 32'hFFFF_FFFF);
    push_cmd(CMD_CLEAR, $urandom(), $urandom());
    push_cmd(CMD_QUERY, $urandom(), 32'hFFFF_FFFF);
    push_cmd(CMD_INSERT, $urandom(), $urandom());
    push_cmd(CMD_QUERY, $urandom(), 32'hFFFF_FFFF);
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || holding || answer_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_pct = 34;
    // directed pass
    push_cmd(CMD_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF);  // empty store
    push_cmd(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    push_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    push_cmd(CMD_INSERT, 32'h8000_0000, 32'h0000_1234);
    push_cmd(CMD_INSERT, 32'h8000_0000, 32'h0000_0000);  // duplicate
    push_cmd(CMD_INSERT, 32'h1234_5678, 32'h0000_0000);
    push_cmd(CMD_QUERY,  32'h0000_0000, 32'hFFFF_FFFF);
    push_cmd(CMD_QUERY,  32'hFFFF_FFFF, 32'h0000_0000);
    push_cmd(CMD_QUERY,  32'h0000_0000, 32'h0000_0000);
    push_cmd(CMD_QUERY,  32'h0000_0005, 32'h7FFF_FFFF);
    push_cmd(CMD_QUERY,  32'hAAAA_AAAA, 32'h8000_0000);
    push_cmd(CMD_QUERY,  32'h8000_0000, 32'h7FFF_FFFE);
    push_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(CMD_QUERY,  32'h5555_5555, 32'hFFFF_FFFF);  // store untouched by unused code
    push_cmd(CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(CMD_QUERY,  32'h0000_0000, 32'hFFFF_FFFF);
    push_cmd(CMD_INSERT, 32'h0000_0007, 32'hFFFF_FFFF);
    push_cmd(CMD_QUERY,  32'h0000_0007, 32'h0000_0006);  // nothing under the limit
    push_cmd(CMD_QUERY,  32'h0000_0007, 32'h0000_0007);
    push_cmd(CMD_UNUSED, 32'h0000_0000, 32'h0000_0000);
    push_cmd(CMD_CLEAR,  32'h0000_0000, 32'h0000_0000);
    run_mix(80);
    drain();

    idle_pct = 83;
    run_mix(40);
    drain();

    idle_pct = 0;
    run_fill();
    run_mix(20);
    drain();

    repeat (CAPACITY + 8) @(posedge clk);
    $display("run covered %0d commands: %0d queries (%0d with an eligible value),",
             n_cmds, n_queries, n_found);
    $display("%0d refused inserts, sender idle rates 34, 83 and 0 percent; %0d errors",
             n_dropped, n_errors);
    if (n_errors == 0 && answer_q.size() == 0) begin
      $display("PASS bounded_max_xor_search");
    end else begin
      $display("FAIL bounded_max_xor_search");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bmx_pkg.sv
rtl/bmx_cell.sv
rtl/bounded_max_xor_search.sv
rtl/bmx_checker.sv
sim/tb_bounded_max_xor_search.sv
